// ----- design/chacha_pkg.sv -----
// Package for the ChaCha20 stream cipher core: widths, register indexes,
// sigma constants and the word-index and rotate helpers of the round unit.
// No dependencies.
`default_nettype none

package chacha_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int BYTE_W     = 8;
	localparam int WORD_W     = 32;
	localparam int NUM_WORDS  = 16;
	localparam int NUM_LANES  = 4;
	localparam int DEF_DOUBLE_ROUNDS = 10;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_0_7    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_8_15   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_16_23  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_24_31  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NONCE_0_7  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NONCE_8_11 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_CTR   = 3'd6;

	localparam logic [WORD_W-1:0] SIGMA_0 = 32'h61707865;
	localparam logic [WORD_W-1:0] SIGMA_1 = 32'h3320646e;
	localparam logic [WORD_W-1:0] SIGMA_2 = 32'h79622d32;
	localparam logic [WORD_W-1:0] SIGMA_3 = 32'h6b206574;

	// Word index of one operand of a quarter round: row 0..3 selects a, b, c, d.
	// Diagonal rounds shift the column by the row number.
	function automatic logic [3:0] lane_word(input logic diag, input int row, input int lane);
		logic [1:0] col;
		col = 2'(lane + (diag ? row : 0));
		return {2'(row), col};
	endfunction

	// Rotate left by 16, 12, 8 or 7 for the four steps of a quarter round.
	function automatic logic [WORD_W-1:0] rotl_step(input logic [WORD_W-1:0] v,
			input logic [1:0] step);
		logic [WORD_W-1:0] r;
		case (step)
			2'd0: r = {v[15:0], v[31:16]};
			2'd1: r = {v[19:0], v[31:20]};
			2'd2: r = {v[23:0], v[31:24]};
			2'd3: r = {v[24:0], v[31:25]};
			default: r = v;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- design/chacha20_stream_cipher_core.sv -----
// Top level of the ChaCha20 stream cipher core: byte stream in, byte stream out,
// with the key, nonce and counter registers and the iterative round unit.
// Depends on chacha_pkg.
`default_nettype none

// The core XORs each data byte with the next byte of a 64-byte ChaCha20 keystream
// block, little-endian within each word. A byte that finds a block buffered is
// accepted as its result goes into the output register, so a running message moves
// one byte per cycle unless the output stalls. A byte that needs a new block
// holds off input until the keystream is ready: the state is loaded on accept, a unit
// of four quarter-round lanes does one add, XOR and rotate step per cycle, four steps
// per round, then the final state adds the input words and the emit state registers
// the byte. The block counter increments after each block and wraps silently. A beat
// with tlast set drops the rest of the block. Writing the initial counter reloads the
// counter and drops the buffered block; key and nonce writes take effect with the
// next block. Configuration must be written only while idle; unchecked by the core.
module chacha20_stream_cipher_core #(
	parameter int DOUBLE_ROUNDS = chacha_pkg::DEF_DOUBLE_ROUNDS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [chacha_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [chacha_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [chacha_pkg::BYTE_W-1:0]     s_tdata,  // [7:0] data_byte
	input  wire logic                              s_tlast,  // last_byte
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [chacha_pkg::BYTE_W-1:0]          m_tdata,  // [7:0] out_byte
	output logic                                   m_tlast   // end_of_message
);
	import chacha_pkg::*;

	localparam int DrW = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;
	localparam logic [DrW-1:0] DrLast = DrW'(DOUBLE_ROUNDS - 1);

	typedef enum logic [1:0] {ST_IDLE, ST_ROUND, ST_FINAL, ST_EMIT} state_t;

	state_t              state_q;
	logic [1:0]          step_q;
	logic                diag_q;
	logic [DrW-1:0]      dr_q;
	logic                ks_ready_q;
	logic [5:0]          pos_q;
	logic                m_valid_q;
	logic [WORD_W-1:0]   counter_q;
	logic [63:0]         key0_q, key1_q, key2_q, key3_q, nonce0_q;
	logic [WORD_W-1:0]   nonce1_q;

	logic [WORD_W-1:0]   w_q [NUM_WORDS];
	logic [BYTE_W-1:0]   dat_q;
	logic                lst_q;
	logic [BYTE_W-1:0]   m_data_q;
	logic                m_last_q;

	logic [WORD_W-1:0]   init_w [NUM_WORDS];
	logic [WORD_W-1:0]   sum_w  [NUM_LANES];
	logic [WORD_W-1:0]   rot_w  [NUM_LANES];
	logic [WORD_W-1:0]   ks_word;
	logic [BYTE_W-1:0]   ks_byte;
	logic                accept;
	logic                use_byte;
	logic                use_last;
	logic [5:0]          pos_next;

	assign s_tready = (state_q == ST_IDLE) && (!m_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;

	assign ks_word  = w_q[pos_q[5:2]];
	assign ks_byte  = ks_word[{pos_q[1:0], 3'b000} +: BYTE_W];
	assign use_byte = (accept && ks_ready_q) || (state_q == ST_EMIT);
	assign use_last = (state_q == ST_EMIT) ? lst_q : s_tlast;
	assign pos_next = pos_q + 6'd1;

	always_comb begin
		init_w[0]  = SIGMA_0;
		init_w[1]  = SIGMA_1;
		init_w[2]  = SIGMA_2;
		init_w[3]  = SIGMA_3;
		init_w[4]  = key0_q[31:0];
		init_w[5]  = key0_q[63:32];
		init_w[6]  = key1_q[31:0];
		init_w[7]  = key1_q[63:32];
		init_w[8]  = key2_q[31:0];
		init_w[9]  = key2_q[63:32];
		init_w[10] = key3_q[31:0];
		init_w[11] = key3_q[63:32];
		init_w[12] = counter_q;
		init_w[13] = nonce0_q[31:0];
		init_w[14] = nonce0_q[63:32];
		init_w[15] = nonce1_q;
	end

	// Four quarter-round lanes; even steps update a and d, odd steps c and b.
	always_comb begin
		logic [WORD_W-1:0] va, vb, vc, vd, p, q, t;
		for (int l = 0; l < NUM_LANES; l++) begin
			va = w_q[lane_word(1'b0, 0, l)];
			vb = diag_q ? w_q[lane_word(1'b1, 1, l)] : w_q[lane_word(1'b0, 1, l)];
			vc = diag_q ? w_q[lane_word(1'b1, 2, l)] : w_q[lane_word(1'b0, 2, l)];
			vd = diag_q ? w_q[lane_word(1'b1, 3, l)] : w_q[lane_word(1'b0, 3, l)];
			p  = step_q[0] ? vc : va;
			q  = step_q[0] ? vd : vb;
			t  = step_q[0] ? vb : vd;
			sum_w[l] = p + q;
			rot_w[l] = rotl_step(t ^ sum_w[l], step_q);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept && !ks_ready_q) begin
					for (int i = 0; i < NUM_WORDS; i++) begin
						w_q[i] <= init_w[i];
					end
					dat_q <= s_tdata;
					lst_q <= s_tlast;
				end
				if (accept && ks_ready_q) begin
					m_data_q <= s_tdata ^ ks_byte;
					m_last_q <= s_tlast;
				end
			end
			ST_ROUND: begin
				for (int l = 0; l < NUM_LANES; l++) begin
					if (!step_q[0]) begin
						w_q[lane_word(1'b0, 0, l)] <= sum_w[l];
						if (diag_q) begin
							w_q[lane_word(1'b1, 3, l)] <= rot_w[l];
						end else begin
							w_q[lane_word(1'b0, 3, l)] <= rot_w[l];
						end
					end else begin
						if (diag_q) begin
							w_q[lane_word(1'b1, 2, l)] <= sum_w[l];
							w_q[lane_word(1'b1, 1, l)] <= rot_w[l];
						end else begin
							w_q[lane_word(1'b0, 2, l)] <= sum_w[l];
							w_q[lane_word(1'b0, 1, l)] <= rot_w[l];
						end
					end
				end
			end
			ST_FINAL: begin
				for (int i = 0; i < NUM_WORDS; i++) begin
					w_q[i] <= w_q[i] + init_w[i];
				end
			end
			ST_EMIT: begin
				m_data_q <= dat_q ^ ks_byte;
				m_last_q <= lst_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_q     <= 2'd0;
			diag_q     <= 1'b0;
			dr_q       <= '0;
			ks_ready_q <= 1'b0;
			pos_q      <= 6'd0;
			m_valid_q  <= 1'b0;
			counter_q  <= '0;
			key0_q     <= '0;
			key1_q     <= '0;
			key2_q     <= '0;
			key3_q     <= '0;
			nonce0_q   <= '0;
			nonce1_q   <= '0;
		end else begin
			if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			if (use_byte) begin
				m_valid_q <= 1'b1;
				if (pos_next == 6'd0 || use_last) begin
					ks_ready_q <= 1'b0;
					pos_q      <= 6'd0;
				end else begin
					ks_ready_q <= 1'b1;
					pos_q      <= pos_next;
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (accept && !ks_ready_q) begin
						step_q  <= 2'd0;
						diag_q  <= 1'b0;
						dr_q    <= '0;
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) begin
						diag_q <= ~diag_q;
						if (diag_q) begin
							if (dr_q == DrLast) begin
								state_q <= ST_FINAL;
							end else begin
								dr_q <= dr_q + DrW'(1);
							end
						end
					end
				end
				ST_FINAL: begin
					counter_q <= counter_q + 32'd1;
					state_q   <= ST_EMIT;
				end
				ST_EMIT: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (cfg_we) begin
				case (cfg_index)
					REG_KEY_0_7:    key0_q   <= cfg_data;
					REG_KEY_8_15:   key1_q   <= cfg_data;
					REG_KEY_16_23:  key2_q   <= cfg_data;
					REG_KEY_24_31:  key3_q   <= cfg_data;
					REG_NONCE_0_7:  nonce0_q <= cfg_data;
					REG_NONCE_8_11: nonce1_q <= cfg_data[WORD_W-1:0];
					REG_INIT_CTR: begin
						counter_q  <= cfg_data[WORD_W-1:0];
						ks_ready_q <= 1'b0;
						pos_q      <= 6'd0;
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for chacha20_stream_cipher_core: random and directed byte streams are
// checked against an in-bench ChaCha20 keystream predictor, with stalls on both sides.
// Depends on chacha_pkg and chacha20_stream_cipher_core.

module tb_top;
	import chacha_pkg::*;

	localparam int N_DOUBLE_ROUNDS = DEF_DOUBLE_ROUNDS;
	localparam int MAX_CYCLES      = 1000000;
	localparam int HOLD_CYCLES     = 400;
	localparam int DRAIN_SLACK     = 4;
	localparam int TAIL_CYCLES     = 100;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [15:0][WORD_W-1:0] blk_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              eom;
	} cipher_beat_t;

	localparam cfg_idx_t REG_UNUSED = cfg_idx_t'(7);

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	cfg_idx_t              cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [BYTE_W-1:0]     s_tdata   = '0;
	logic                  s_tlast   = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [BYTE_W-1:0]     m_tdata;
	logic                  m_tlast;

	// Predictor state: registers, block counter and the buffered keystream block.
	logic [63:0]       key_q [4];
	logic [63:0]       nonce_lo_q  = '0;
	logic [31:0]       nonce_hi_q  = '0;
	logic [31:0]       ctr_q       = '0;
	blk_t              ks_blk      = '0;
	logic [5:0]        ks_pos      = '0;
	logic              ks_live     = 1'b0;

	cipher_beat_t expected_beats[$];
	int mismatch_count = 0;
	int beats_checked  = 0;
	int bytes_sent     = 0;
	int reg_writes     = 0;
	int cycle_count    = 0;
	int hold_reqs      = 0;
	int hold_seen      = 0;
	int stall_left     = 0;
	bit tx_idle_on     = 1'b1;
	bit rx_idle_on     = 1'b1;

	chacha20_stream_cipher_core #(
		.DOUBLE_ROUNDS(N_DOUBLE_ROUNDS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == MAX_CYCLES) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic blk_t quarter_round(input blk_t w, input int a, input int b,
			input int c, input int d);
		w[a] = w[a] + w[b]; w[d] = rotl32(w[d] ^ w[a], 16);
		w[c] = w[c] + w[d]; w[b] = rotl32(w[b] ^ w[c], 12);
		w[a] = w[a] + w[b]; w[d] = rotl32(w[d] ^ w[a], 8);
		w[c] = w[c] + w[d]; w[b] = rotl32(w[b] ^ w[c], 7);
		return w;
	endfunction

	function automatic blk_t chacha_keystream(input blk_t init);
		blk_t w;
		int r;
		int i;
		w = init;
		for (r = 0; r < N_DOUBLE_ROUNDS; r++) begin
			w = quarter_round(w, 0, 4, 8, 12);
			w = quarter_round(w, 1, 5, 9, 13);
			w = quarter_round(w, 2, 6, 10, 14);
			w = quarter_round(w, 3, 7, 11, 15);
			w = quarter_round(w, 0, 5, 10, 15);
			w = quarter_round(w, 1, 6, 11, 12);
			w = quarter_round(w, 2, 7, 8, 13);
			w = quarter_round(w, 3, 4, 9, 14);
		end
		for (i = 0; i < 16; i++)
			w[i] = w[i] + init[i];
		return w;
	endfunction

	task automatic predict_cipher(input logic [BYTE_W-1:0] d, input logic l);
		blk_t init;
		logic [31:0] w;
		cipher_beat_t e;
		int k;
		if (!ks_live) begin
			init[0] = SIGMA_0;
			init[1] = SIGMA_1;
			init[2] = SIGMA_2;
			init[3] = SIGMA_3;
			for (k = 0; k < 4; k++) begin
				init[4 + 2 * k] = key_q[k][31:0];
				init[5 + 2 * k] = key_q[k][63:32];
			end
			init[12] = ctr_q;
			init[13] = nonce_lo_q[31:0];
			init[14] = nonce_lo_q[63:32];
			init[15] = nonce_hi_q;
			ks_blk   = chacha_keystream(init);
			ctr_q    = ctr_q + 32'd1;
			ks_pos   = '0;
			ks_live  = 1'b1;
		end
		w = ks_blk[ks_pos[5:2]];
		e.out_byte = d ^ w[ks_pos[1:0] * 8 +: 8];
		e.eom      = l;
		expected_beats.push_back(e);
		ks_pos = ks_pos + 6'd1;
		if (ks_pos == 6'd0 || l) begin
			ks_live = 1'b0;
			ks_pos  = '0;
		end
	endtask

	function automatic void model_reg_write(input cfg_idx_t idx, input logic [63:0] val);
		case (idx)
			REG_KEY_0_7:    key_q[0]   = val;
			REG_KEY_8_15:   key_q[1]   = val;
			REG_KEY_16_23:  key_q[2]   = val;
			REG_KEY_24_31:  key_q[3]   = val;
			REG_NONCE_0_7:  nonce_lo_q = val;
			REG_NONCE_8_11: nonce_hi_q = val[31:0];
			REG_INIT_CTR: begin
				ctr_q   = val[31:0];
				ks_live = 1'b0;
				ks_pos  = '0;
			end
			default: ;
		endcase
	endfunction

	function automatic int pick_stall();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic int pick_gap();
		int r;
		if (!tx_idle_on)
			return 0;
		r = $urandom_range(0, 19);
		if (r < 12)
			return 0;
		if (r < 18)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Output side: random stalls, plus one long hold-off on request.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (stall_left != 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (hold_reqs != hold_seen) begin
			hold_seen  <= hold_reqs;
			m_tready   <= 1'b0;
			stall_left <= HOLD_CYCLES - 1;
		end else if (!rx_idle_on || $urandom_range(0, 3) != 0) begin
			m_tready <= 1'b1;
		end else begin
			m_tready   <= 1'b0;
			stall_left <= pick_stall() - 1;
		end
	end

	always @(posedge clk) begin
		cipher_beat_t e;
		if (arst_n && m_tvalid && m_tready) begin
			beats_checked++;
			if (expected_beats.size() == 0) begin
				$error("unexpected output beat: out_byte %02h, end_of_message %0b",
					m_tdata, m_tlast);
				mismatch_count++;
			end else begin
				e = expected_beats.pop_front();
				if (m_tdata !== e.out_byte || m_tlast !== e.eom)
					mismatch_count++;
				if (m_tdata !== e.out_byte)
					$error("out_byte: expected %02h, got %02h", e.out_byte, m_tdata);
				if (m_tlast !== e.eom)
					$error("end_of_message: expected %0b, got %0b", e.eom, m_tlast);
			end
		end
	end

	task automatic send_byte(input logic [BYTE_W-1:0] d, input logic l);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		s_tlast  <= l;
		do @(posedge clk); while (!s_tready);
		predict_cipher(d, l);
		bytes_sent++;
	endtask

	task automatic send_message(input int len, input bit ends_msg);
		int i;
		for (i = 0; i < len; i++)
			send_byte(BYTE_W'($urandom_range(0, 255)), ends_msg && (i == len - 1));
	endtask

	task automatic drain_outputs();
		s_tvalid <= 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [63:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		model_reg_write(idx, val);
		reg_writes++;
		@(posedge clk);
	endtask

	task automatic load_config(input logic [63:0] k0, input logic [63:0] k1,
			input logic [63:0] k2, input logic [63:0] k3, input logic [63:0] n_lo,
			input logic [63:0] n_hi, input logic [63:0] ctr);
		write_reg(REG_KEY_0_7, k0);
		write_reg(REG_KEY_8_15, k1);
		write_reg(REG_KEY_16_23, k2);
		write_reg(REG_KEY_24_31, k3);
		write_reg(REG_NONCE_0_7, n_lo);
		write_reg(REG_NONCE_8_11, n_hi);
		write_reg(REG_INIT_CTR, ctr);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic test_reset_state();
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b1);
	endtask

	// Key, nonce and counter of the block function example in RFC 8439.
	task automatic test_known_block();
		drain_outputs();
		load_config(64'h07060504_03020100, 64'h0f0e0d0c_0b0a0908,
			64'h17161514_13121110, 64'h1f1e1d1c_1b1a1918,
			64'h4a000000_09000000, 64'h0, 64'h1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h01, 1'b1);
	endtask

	task automatic test_unused_index();
		drain_outputs();
		write_reg(REG_UNUSED, 64'hffffffff_ffffffff);
		send_byte(8'h5a, 1'b0);
		send_byte(8'ha5, 1'b1);
	endtask

	task automatic test_counter_wrap();
		drain_outputs();
		write_reg(REG_INIT_CTR, 64'hffffffff_ffffffff);
		send_byte(8'h00, 1'b1);
		send_byte(8'h00, 1'b1);
		send_byte(8'hff, 1'b1);
	endtask

	// A key write keeps the buffered block; a counter write drops it.
	task automatic test_writes_mid_block();
		send_message(3, 1'b0);
		drain_outputs();
		write_reg(REG_KEY_0_7, rand64());
		send_message(2, 1'b1);
		send_message(1, 1'b1);
		send_message(2, 1'b0);
		drain_outputs();
		write_reg(REG_INIT_CTR, rand64());
		send_message(1, 1'b1);
	endtask

	task automatic run_random_phase(input int n_items);
		int sent;
		int len;
		int r;
		bit ends_msg;
		sent = 0;
		while (sent < n_items) begin
			r = $urandom_range(0, 99);
			if (r < 65)
				len = $urandom_range(1, 16);
			else if (r < 85)
				len = $urandom_range(62, 66);
			else
				len = $urandom_range(100, 200);
			ends_msg = ($urandom_range(0, 99) < 85);
			send_message(len, ends_msg);
			sent += len;
			if (!ends_msg && $urandom_range(0, 3) == 0) begin
				drain_outputs();
				write_reg(cfg_idx_t'($urandom_range(0, 7)), rand64());
			end
		end
	endtask

	task automatic test_random_traffic();
		int ph;
		for (ph = 0; ph < 6; ph++) begin
			drain_outputs();
			case (ph)
				0: load_config('0, '0, '0, '0, '0, '0, '0);
				1: load_config('1, '1, '1, '1, '1, '1, 64'hffffffff_fffffffe);
				default: load_config(rand64(), rand64(), rand64(), rand64(), rand64(),
					rand64(), rand64());
			endcase
			tx_idle_on = (ph != 2);
			rx_idle_on <= (ph != 2);
			run_random_phase(140);
		end
	endtask

	task automatic test_backpressure();
		drain_outputs();
		tx_idle_on = 1'b0;
		hold_reqs <= hold_reqs + 1;
		send_message(80, 1'b1);
		tx_idle_on = 1'b1;
		drain_outputs();
		send_message(30, 1'b1);
		send_message(70, 1'b0);
	endtask

	initial begin
		key_q[0] = '0;
		key_q[1] = '0;
		key_q[2] = '0;
		key_q[3] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_known_block();
		test_unused_index();
		test_counter_wrap();
		test_writes_mid_block();
		test_random_traffic();
		test_backpressure();
		drain_outputs();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d bytes and checked %0d output beats in %0d cycles.",
			bytes_sent, beats_checked, cycle_count);
		$display("Covered %0d register writes, counter wrap, block refills and a long stall.",
			reg_writes);
		if (mismatch_count == 0 && expected_beats.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
